>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> rtl/pcan_pkg.sv
// ----------------------------------------------------------------------------
// pcan_pkg
// Types and constants shared by the path canonicalizer modules.
// ----------------------------------------------------------------------------
package pcan_pkg;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Depth of the token queue between the loader and the scanner.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY_IN  = 3'd1,
    ST_EMPTY_OUT = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_has_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_has_char;
    logic       out_last;
    logic [2:0] status;
  } out_item_t;

  // One classified character, or the end marker of a path.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       is_slash;
    logic       is_dot;
    logic       last;
    logic       overflow;
  } token_t;

endpackage

>>> rtl/path_canonicalizer.sv
// ----------------------------------------------------------------------------
// path_canonicalizer
// Removes dot segments, empty segments and the trailing slash from a path.
//
// Input channel (push/full): one path byte per transaction; in_last marks the
// end of a path, in_has_char = 0 marks a transaction without a byte.
// Result channel (empty/pop): the canonical path one byte per transaction,
// out_last on the final one, or a single transaction without a byte that
// carries the status (empty input, empty result, too many components, too
// long). Root-only paths give one transaction with status ok and no byte.
// Each byte passes through the loader and the scanner; the scanner then
// streams the output bytes and finishes each path in its end and result
// states. The scanner handles one path at a time, loading of the next path
// runs ahead through a four-entry token queue. Reset empties the queue and
// the result register. A stalled receiver holds the result register, the
// scanner, and then the loader via full_o.
// ----------------------------------------------------------------------------
module path_canonicalizer import pcan_pkg::*; #(
  parameter int unsigned MAX_PATH_LEN   = 64,
  parameter int unsigned MAX_COMPONENTS = 30
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  in_data_i,
  output logic      full_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_data_o
);

  logic   fe_valid, q_ready, q_valid, be_pop;
  token_t fe_tok, q_tok;

  pcan_front #(
    .MAX_PATH_LEN(MAX_PATH_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_data_i  (in_data_i),
    .full_o     (full_o),
    .tok_valid_o(fe_valid),
    .tok_o      (fe_tok),
    .tok_ready_i(q_ready)
  );

  pcan_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fe_valid),
    .data_i (fe_tok),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .data_o (q_tok),
    .pop_i  (be_pop)
  );

  pcan_back #(
    .MAX_PATH_LEN  (MAX_PATH_LEN),
    .MAX_COMPONENTS(MAX_COMPONENTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_valid_i(q_valid),
    .tok_i      (q_tok),
    .tok_pop_o  (be_pop),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/pcan_ram.sv
// ----------------------------------------------------------------------------
// pcan_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pcan_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/pcan_front.sv
// ----------------------------------------------------------------------------
// pcan_front
// Input loader: counts path bytes, drops the excess and classifies each byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcan_front import pcan_pkg::*; #(
  parameter int unsigned MAX_PATH_LEN = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_data_i,
  output logic     full_o,
  output logic     tok_valid_o,
  output token_t   tok_o,
  input  logic     tok_ready_i
);

  localparam int unsigned LenW = $clog2(MAX_PATH_LEN + 1);

  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            accept, keep, drop;

  assign full_o = !tok_ready_i;
  assign accept = push_i && tok_ready_i;
  assign keep   = in_data_i.in_has_char && (len_q < LenW'(MAX_PATH_LEN));
  assign drop   = in_data_i.in_has_char && !keep;

  // Bytes past the buffer length and empty non-final items produce no token.
  assign tok_valid_o    = accept && (in_data_i.in_last || keep);
  assign tok_o.ch       = in_data_i.in_char;
  assign tok_o.has_char = keep;
  assign tok_o.is_slash = (in_data_i.in_char == CH_SLASH);
  assign tok_o.is_dot   = (in_data_i.in_char == CH_DOT);
  assign tok_o.last     = in_data_i.in_last;
  assign tok_o.overflow = ovf_q || drop;

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (in_data_i.in_last) begin
        len_d = '0;
        ovf_d = 1'b0;
      end else begin
        if (keep) begin
          len_d = len_q + LenW'(1);
        end
        if (drop) begin
          ovf_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  `ASSERT_PROP(a_front_restart, (accept && in_data_i.in_last) |=> (len_q == '0 && !ovf_q), "loader did not restart after the final item")
  `ASSERT_NEVER(a_front_len, len_q > LenW'(MAX_PATH_LEN), "loader count ran past the buffer length")

endmodule

>>> rtl/pcan_fifo.sv
// ----------------------------------------------------------------------------
// pcan_fifo
// Short token queue that decouples the loader from the scanner.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcan_fifo import pcan_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t data_i,
  output logic   ready_o,
  output logic   valid_o,
  output token_t data_o,
  input  logic   pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  token_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `ASSERT_NEVER(a_fifo_count, cnt_q > CntW'(QUEUE_DEPTH), "token queue count exceeds its depth")

endmodule

>>> rtl/pcan_back.sv
// ----------------------------------------------------------------------------
// pcan_back
// Scanner and emitter: removes dot segments into a work RAM, then streams
// the canonical path out through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcan_back import pcan_pkg::*; #(
  parameter int unsigned MAX_PATH_LEN   = 64,
  parameter int unsigned MAX_COMPONENTS = 30
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      tok_valid_i,
  input  token_t    tok_i,
  output logic      tok_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_data_o
);

  localparam int unsigned DstW  = $clog2(MAX_PATH_LEN + 2);
  localparam int unsigned AddrW = $clog2(MAX_PATH_LEN);
  localparam int unsigned CntW  = $clog2(MAX_COMPONENTS + 1);
  localparam int unsigned StkW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  typedef enum logic [4:0] {
    S_SCAN   = 5'b00001,
    S_END    = 5'b00010,
    S_RESULT = 5'b00100,
    S_SINGLE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [DstW-1:0] dst_q, dst_d;
  logic [DstW-1:0] seg_dst_q, seg_dst_d;
  logic [1:0]      seg_len_q, seg_len_d;
  logic            seg_dots_q, seg_dots_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DstW-1:0] stack_q [MAX_COMPONENTS];
  logic            seen_q, seen_d;
  logic            err_q, err_d;
  logic            ovf_q, ovf_d;
  status_e         status_q, status_d;
  logic [AddrW-1:0] k_q, k_d;
  logic [AddrW-1:0] n_last_q, n_last_d;
  out_item_t       out_q, out_d;
  logic            out_vld_q;

  logic             out_free, out_load;
  logic             do_term, stk_we, wr_req, wr_en, rd_en;
  logic [7:0]       wr_data, term_ch, rd_data;
  logic [AddrW-1:0] rd_addr;
  logic [CntW-1:0]  cnt_m1;
  logic [DstW-1:0]  stack_top;
  logic             seg_skip, seg_dotdot, stack_full;

  assign out_free   = !out_vld_q || pop_i;
  assign empty_o    = !out_vld_q;
  assign out_data_o = out_q;

  assign cnt_m1     = cnt_q - CntW'(1);
  assign stack_top  = stack_q[cnt_m1[StkW-1:0]];
  assign seg_skip   = (seg_len_q == 2'd0) || (seg_len_q == 2'd1 && seg_dots_q);
  assign seg_dotdot = (seg_len_q == 2'd2) && seg_dots_q;
  assign stack_full = (cnt_q == CntW'(MAX_COMPONENTS));

  // The terminator of the last segment is written too; it never reaches the
  // output since the final written byte is always dropped.
  assign wr_en = wr_req && (dst_q < DstW'(MAX_PATH_LEN));

  always_comb begin
    state_d    = state_q;
    dst_d      = dst_q;
    seg_dst_d  = seg_dst_q;
    seg_len_d  = seg_len_q;
    seg_dots_d = seg_dots_q;
    cnt_d      = cnt_q;
    seen_d     = seen_q;
    err_d      = err_q;
    ovf_d      = ovf_q;
    status_d   = status_q;
    k_d        = k_q;
    n_last_d   = n_last_q;
    out_d      = out_q;
    out_load   = 1'b0;
    tok_pop_o  = 1'b0;
    do_term    = 1'b0;
    stk_we     = 1'b0;
    wr_req     = 1'b0;
    wr_data    = tok_i.ch;
    term_ch    = CH_SLASH;
    rd_en      = 1'b0;
    rd_addr    = k_q + AddrW'(1);

    unique case (state_q)
      S_SCAN: begin
        if (tok_valid_i) begin
          tok_pop_o = 1'b1;
          if (tok_i.has_char) begin
            seen_d = 1'b1;
            if (!err_q) begin
              if (!seen_q && tok_i.is_slash) begin
                // A leading slash is kept and opens the first segment.
                wr_req    = 1'b1;
                dst_d     = DstW'(1);
                seg_dst_d = DstW'(1);
              end else if (tok_i.is_slash) begin
                do_term = 1'b1;
              end else begin
                wr_req     = 1'b1;
                dst_d      = dst_q + DstW'(1);
                seg_len_d  = (seg_len_q == 2'd3) ? 2'd3 : seg_len_q + 2'd1;
                seg_dots_d = seg_dots_q && tok_i.is_dot;
              end
            end
          end
          if (tok_i.last) begin
            ovf_d   = tok_i.overflow;
            state_d = S_END;
          end
        end
      end

      S_END: begin
        term_ch = CH_NUL;
        do_term = !err_q;
        state_d = S_RESULT;
      end

      S_RESULT: begin
        state_d = S_SINGLE;
        if (ovf_q) begin
          status_d = ST_TOO_LONG;
        end else if (!seen_q) begin
          status_d = ST_EMPTY_IN;
        end else if (err_q) begin
          status_d = ST_TOO_MANY;
        end else if (dst_q == '0) begin
          status_d = ST_EMPTY_OUT;
        end else if (dst_q == DstW'(1)) begin
          status_d = ST_OK;
        end else begin
          n_last_d = AddrW'(dst_q - DstW'(2));
          k_d      = '0;
          rd_en    = 1'b1;
          rd_addr  = '0;
          state_d  = S_EMIT;
        end
        dst_d      = '0;
        seg_dst_d  = '0;
        seg_len_d  = 2'd0;
        seg_dots_d = 1'b1;
        cnt_d      = '0;
        seen_d     = 1'b0;
        err_d      = 1'b0;
        ovf_d      = 1'b0;
      end

      S_SINGLE: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_d.out_char     = CH_NUL;
          out_d.out_has_char = 1'b0;
          out_d.out_last     = 1'b1;
          out_d.status       = status_q;
          state_d            = S_SCAN;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_d.out_char     = rd_data;
          out_d.out_has_char = 1'b1;
          out_d.out_last     = (k_q == n_last_q);
          out_d.status       = ST_OK;
          if (k_q == n_last_q) begin
            state_d = S_SCAN;
          end else begin
            rd_en = 1'b1;
            k_d   = k_q + AddrW'(1);
          end
        end
      end

      default: begin
        state_d = S_SCAN;
      end
    endcase

    // End of a segment, at a slash or at the end of the path.
    if (do_term) begin
      seg_len_d  = 2'd0;
      seg_dots_d = 1'b1;
      if (seg_skip) begin
        dst_d     = seg_dst_q;
        seg_dst_d = seg_dst_q;
      end else if (seg_dotdot && cnt_q != '0) begin
        dst_d     = stack_top;
        seg_dst_d = stack_top;
        cnt_d     = cnt_m1;
      end else if (seg_dotdot) begin
        // Nothing left to remove: the dots stay and are not recorded.
        wr_req    = 1'b1;
        wr_data   = term_ch;
        dst_d     = dst_q + DstW'(1);
        seg_dst_d = dst_q + DstW'(1);
      end else if (stack_full) begin
        err_d = 1'b1;
      end else begin
        stk_we    = 1'b1;
        cnt_d     = cnt_q + CntW'(1);
        wr_req    = 1'b1;
        wr_data   = term_ch;
        dst_d     = dst_q + DstW'(1);
        seg_dst_d = dst_q + DstW'(1);
      end
    end
  end

  pcan_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PATH_LEN)
  ) u_work_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(dst_q[AddrW-1:0]),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_q[cnt_q[StkW-1:0]] <= seg_dst_q;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    k_q      <= k_d;
    n_last_q <= n_last_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_SCAN;
      dst_q      <= '0;
      seg_dst_q  <= '0;
      seg_len_q  <= 2'd0;
      seg_dots_q <= 1'b1;
      cnt_q      <= '0;
      seen_q     <= 1'b0;
      err_q      <= 1'b0;
      ovf_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      dst_q      <= dst_d;
      seg_dst_q  <= seg_dst_d;
      seg_len_q  <= seg_len_d;
      seg_dots_q <= seg_dots_d;
      cnt_q      <= cnt_d;
      seen_q     <= seen_d;
      err_q      <= err_d;
      ovf_q      <= ovf_d;
      out_vld_q  <= out_load || (out_vld_q && !pop_i);
    end
  end

  `ASSERT_NEVER(a_back_cnt, cnt_q > CntW'(MAX_COMPONENTS), "component count exceeds the stack depth")
  `ASSERT_NEVER(a_back_dst, dst_q > DstW'(MAX_PATH_LEN + 1), "write pointer ran past the work buffer")
  `ASSERT_PROP(a_back_emit_end, (state_q == S_EMIT && state_d != S_EMIT) |-> (out_load && out_d.out_last), "emission ended without a final transaction")

endmodule

>>> sim/path_canonicalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_canonicalizer_tb
// Feeds paths into the canonicalizer one byte per transaction and checks
// every result byte and status against a behavioral predictor. A directed
// set covers the root, empty input, empty result, literal dot-dot runs, byte
// extremes, byte-less transactions and both limits. Random paths follow,
// mostly well-formed with a share of raw noise and long component chains.
// Both channels idle at random, except for a stretch at full rate.
// ----------------------------------------------------------------------------
module path_canonicalizer_tb;
  import pcan_pkg::*;

  localparam int unsigned PATH_LEN     = 64;
  localparam int unsigned MAX_COMPS    = 30;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  class canon_scoreboard;
    logic [7:0]  path_bytes [0:PATH_LEN];
    logic [7:0]  work [0:PATH_LEN];
    int unsigned comp_starts [0:MAX_COMPS-1];
    int unsigned load_len;
    bit          too_long;
    int unsigned wr_pos;
    out_item_t   canon_bytes_due [$];
    int unsigned errors;

    function new();
      foreach (path_bytes[i]) path_bytes[i] = CH_NUL;
      foreach (comp_starts[i]) comp_starts[i] = 0;
      load_len = 0;
      too_long = 1'b0;
      errors   = 0;
    endfunction

    function void expect_status(status_e st);
      canon_bytes_due.push_back('{out_char: CH_NUL, out_has_char: 1'b0, out_last: 1'b1,
                                  status: st});
    endfunction

    function void emit(logic [7:0] ch);
      if (wr_pos <= PATH_LEN) work[wr_pos] = ch;
      wr_pos++;
    endfunction

    // Loads one accepted byte; on the end of a path, predicts its output.
    function void take_path_byte(in_item_t it);
      int unsigned len, src, ncomp, n;
      bit          overflowed, too_many;
      if (it.in_has_char) begin
        if (load_len < PATH_LEN) begin
          path_bytes[load_len] = it.in_char;
          load_len++;
        end else begin
          too_long = 1'b1;
        end
      end
      if (!it.in_last) return;
      len        = load_len;
      overflowed = too_long;
      load_len   = 0;
      too_long   = 1'b0;
      if (overflowed) begin
        expect_status(ST_TOO_LONG);
        return;
      end
      if (len == 0) begin
        expect_status(ST_EMPTY_IN);
        return;
      end
      foreach (work[i]) work[i] = CH_NUL;
      src      = 0;
      wr_pos   = 0;
      ncomp    = 0;
      too_many = 1'b0;
      if (path_bytes[0] == CH_SLASH) begin
        work[0] = CH_SLASH;
        src     = 1;
        wr_pos  = 1;
      end
      while (src < len && !too_many) begin
        if (path_bytes[src] == CH_DOT &&
            (src + 1 == len || path_bytes[src + 1] == CH_SLASH)) begin
          src += 2;
        end else if (path_bytes[src] == CH_DOT && path_bytes[src + 1] == CH_DOT &&
                     (src + 2 == len || path_bytes[src + 2] == CH_SLASH)) begin
          if (ncomp > 0) begin
            ncomp--;
            wr_pos = comp_starts[ncomp];
            src += 3;
          end else begin
            // With nothing to remove, the dots and their separator stay as they are.
            repeat (3) begin
              emit(src < len ? path_bytes[src] : CH_NUL);
              src++;
            end
          end
        end else if (path_bytes[src] == CH_SLASH) begin
          src++;
        end else if (ncomp >= MAX_COMPS) begin
          too_many = 1'b1;
        end else begin
          comp_starts[ncomp] = wr_pos;
          ncomp++;
          while (src < len && path_bytes[src] != CH_SLASH) begin
            emit(path_bytes[src]);
            src++;
          end
          // The separator is written too; the last one is trimmed below.
          emit(src < len ? path_bytes[src] : CH_NUL);
          src++;
        end
      end
      if (too_many) begin
        expect_status(ST_TOO_MANY);
      end else if (wr_pos == 0) begin
        expect_status(ST_EMPTY_OUT);
      end else begin
        n = (wr_pos - 1 > PATH_LEN) ? PATH_LEN : wr_pos - 1;
        if (n == 0) begin
          expect_status(ST_OK);
        end else begin
          for (int k = 0; k < n; k++) begin
            canon_bytes_due.push_back('{out_char: work[k], out_has_char: 1'b1,
                                        out_last: (k + 1 == n), status: ST_OK});
          end
        end
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_canon_byte(out_item_t got);
      out_item_t want;
      if (canon_bytes_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = canon_bytes_due.pop_front();
      check_field("out_char", want.out_char, got.out_char);
      check_field("out_has_char", want.out_has_char, got.out_has_char);
      check_field("out_last", want.out_last, got.out_last);
      check_field("status", want.status, got.status);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push_i;
  in_item_t    in_data_i;
  logic        full_o;
  logic        empty_o;
  logic        pop_i;
  out_item_t   out_data_o;

  canon_scoreboard sb;
  bit              calm;
  int unsigned     items_sent;
  int unsigned     cycles;

  path_canonicalizer #(
    .MAX_PATH_LEN  (PATH_LEN),
    .MAX_COMPONENTS(MAX_COMPS)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .in_data_i (in_data_i),
    .full_o    (full_o),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Every accepted input transaction goes to the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && push_i && !full_o) sb.take_path_byte(in_data_i);
  end

  // The result side accepts, checks and decides on the next pop.
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) sb.check_canon_byte(out_data_o);
    pop_i <= calm || ($urandom_range(99) >= 20);
  end

  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(99) < 20) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (full_o);
    if (it.in_has_char || it.in_last) items_sent++;
  endtask

  // Sends one path; an empty path is a single byte-less final transaction.
  task automatic send_bytes(input logic [7:0] q[$], input int holes_pct);
    if (q.size() == 0) begin
      send_item('{in_char: 8'($urandom_range(255)), in_has_char: 1'b0, in_last: 1'b1});
      return;
    end
    foreach (q[i]) begin
      if ($urandom_range(99) < holes_pct) begin
        send_item('{in_char: 8'($urandom_range(255)), in_has_char: 1'b0, in_last: 1'b0});
      end
      send_item('{in_char: q[i], in_has_char: 1'b1, in_last: (i == q.size() - 1)});
    end
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q, 0);
  endtask

  initial begin
    logic [7:0]  q[$];
    int unsigned start;
    int unsigned kind, ncomp, r;
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    push_i     = 1'b0;
    pop_i      = 1'b0;
    in_data_i  = '0;
    calm       = 1'b0;
    items_sent = 0;
    cycles     = 0;
    sb         = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_text("/");
    send_text("");
    send_text("a/..");
    send_text("/a/./b/../c/");
    send_text("../x/..");
    send_text("//p//.q/..../");
    send_text("..");
    send_text(".");
    // Byte extremes with a byte-less transaction in between.
    send_item('{in_char: 8'h00, in_has_char: 1'b1, in_last: 1'b0});
    send_item('{in_char: 8'hA5, in_has_char: 1'b0, in_last: 1'b0});
    send_item('{in_char: 8'hFF, in_has_char: 1'b1, in_last: 1'b0});
    send_item('{in_char: 8'h5A, in_has_char: 1'b0, in_last: 1'b1});
    // One byte past the buffer.
    q.delete();
    repeat (PATH_LEN + 1) q.push_back(8'h61);
    send_bytes(q, 0);
    // A full buffer that survives as the longest result.
    q.delete();
    q.push_back(CH_SLASH);
    repeat (PATH_LEN - 1) q.push_back(8'h7A);
    send_bytes(q, 0);
    // One component more than the limit, then the limit with the last removed.
    q.delete();
    repeat (MAX_COMPS + 1) begin
      q.push_back(8'h62);
      q.push_back(CH_SLASH);
    end
    send_bytes(q, 0);
    q.delete();
    repeat (MAX_COMPS) begin
      q.push_back(8'h63);
      q.push_back(CH_SLASH);
    end
    q.push_back(CH_DOT);
    q.push_back(CH_DOT);
    send_bytes(q, 0);

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      calm = (items_sent - start >= 40) && (items_sent - start < 70);
      q.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
        repeat ($urandom_range(12)) q.push_back(8'($urandom_range(255)));
      end else if (kind < 13) begin
        // Long chains of short components reach the component and length limits.
        repeat ($urandom_range(28, 34)) begin
          q.push_back($urandom_range(9) == 0 ? CH_DOT : 8'(8'h61 + $urandom_range(25)));
          q.push_back(CH_SLASH);
        end
      end else begin
        if ($urandom_range(1) == 1) q.push_back(CH_SLASH);
        ncomp = $urandom_range(1, 6);
        for (int c = 0; c < ncomp; c++) begin
          if (c > 0) q.push_back(CH_SLASH);
          r = $urandom_range(9);
          if (r == 0) begin
            q.push_back(CH_DOT);
          end else if (r < 3) begin
            q.push_back(CH_DOT);
            q.push_back(CH_DOT);
          end else if (r > 3) begin
            repeat ($urandom_range(1, 4)) begin
              r = $urandom_range(9);
              if (r < 6) q.push_back(8'(8'h61 + $urandom_range(25)));
              else if (r < 8) q.push_back(CH_DOT);
              else q.push_back(8'($urandom_range(255)));
            end
          end
          // Otherwise the component stays empty and the separator is doubled.
        end
        if ($urandom_range(9) < 3) q.push_back(CH_SLASH);
      end
      send_bytes(q, 5);
    end
    calm = 1'b0;

    push_i <= 1'b0;
    @(posedge clk_i);
    while (sb.canon_bytes_due.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> path_canonicalizer.f
+incdir+rtl
rtl/pcan_pkg.sv
rtl/pcan_ram.sv
rtl/pcan_front.sv
rtl/pcan_fifo.sv
rtl/pcan_back.sv
rtl/path_canonicalizer.sv
sim/path_canonicalizer_tb.sv
